// ----- hw/rtl/pbts_pkg.sv -----
// ----------------------------------------------------------------------------
// pbts_pkg
// Shared types and codes for the fixed-priority bitmap task scheduler.
// ----------------------------------------------------------------------------
package pbts_pkg;

  localparam logic [1:0] OP_CREATE   = 2'd0;
  localparam logic [1:0] OP_RELEASE  = 2'd1;
  localparam logic [1:0] OP_SCHEDULE = 2'd2;
  localparam logic [1:0] OP_YIELD    = 2'd3;

  localparam logic [2:0] ST_CREATED  = 3'd0;
  localparam logic [2:0] ST_FULL     = 3'd1;
  localparam logic [2:0] ST_RELEASED = 3'd2;
  localparam logic [2:0] ST_BAD_ID   = 3'd3;
  localparam logic [2:0] ST_NONE     = 3'd4;
  localparam logic [2:0] ST_SAME     = 3'd5;
  localparam logic [2:0] ST_SWITCHED = 3'd6;
  localparam logic [2:0] ST_UNUSED   = 3'd7;

  localparam int unsigned FIELD_W = 5;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_LEVEL,
    S_MATCH,
    S_PICK,
    S_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic exec;
    logic level;
    logic match;
    logic pick;
    logic push;
  } cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       out_free;
  } stat_t;

endpackage

// ----- hw/rtl/pbts_ctrl.sv -----
// ----------------------------------------------------------------------------
// pbts_ctrl
// Sequencer: steps one transaction through execute and, for schedule and yield,
// level search, task match and pick, then result push.
// ----------------------------------------------------------------------------
module pbts_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_tvalid,
  output logic           s_tready,
  input  pbts_pkg::stat_t stat,
  output pbts_pkg::cmd_t  cmd
);

  pbts_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pbts_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    unique case (state)
      pbts_pkg::S_IDLE: begin
        s_tready = !rst;
        if (s_tvalid && !rst) begin
          cmd.load   = 1'b1;
          state_next = pbts_pkg::S_EXEC;
        end
      end
      pbts_pkg::S_EXEC: begin
        cmd.exec = 1'b1;
        if (stat.op == pbts_pkg::OP_CREATE || stat.op == pbts_pkg::OP_RELEASE) begin
          state_next = pbts_pkg::S_DONE;
        end else begin
          state_next = pbts_pkg::S_LEVEL;
        end
      end
      pbts_pkg::S_LEVEL: begin
        cmd.level  = 1'b1;
        state_next = pbts_pkg::S_MATCH;
      end
      pbts_pkg::S_MATCH: begin
        cmd.match  = 1'b1;
        state_next = pbts_pkg::S_PICK;
      end
      pbts_pkg::S_PICK: begin
        cmd.pick   = 1'b1;
        state_next = pbts_pkg::S_DONE;
      end
      pbts_pkg::S_DONE: begin
        if (stat.out_free) begin
          cmd.push   = 1'b1;
          state_next = pbts_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = pbts_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// ----- hw/rtl/pbts_dp.sv -----
// ----------------------------------------------------------------------------
// pbts_dp
// Datapath: task table, ready marks, level bitmap, running task, search
// registers and the output register.
// ----------------------------------------------------------------------------
module pbts_dp #(
  parameter int unsigned TASK_SLOTS      = 32,
  parameter int unsigned PRIORITY_LEVELS = 32
) (
  input  logic            clk,
  input  logic            rst,
  input  logic [15:0]     s_tdata,
  input  logic [1:0]      s_tuser,
  output logic            m_tvalid,
  input  logic            m_tready,
  output logic [15:0]     m_tdata,
  output logic [3:0]      m_tuser,
  input  pbts_pkg::cmd_t  cmd,
  output pbts_pkg::stat_t stat
);

  localparam int unsigned IW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
  localparam int unsigned CW = $clog2(TASK_SLOTS + 1);
  localparam int unsigned LW = (PRIORITY_LEVELS > 1) ? $clog2(PRIORITY_LEVELS) : 1;
  localparam int unsigned FW = pbts_pkg::FIELD_W;

  logic [1:0]                 op;
  logic [FW-1:0]              id;
  logic [FW-1:0]              pr;
  logic [LW-1:0]              prio [TASK_SLOTS];
  logic [TASK_SLOTS-1:0]      ready;
  logic [PRIORITY_LEVELS-1:0] levels;
  logic [CW-1:0]              count;
  logic [IW-1:0]              run_task;
  logic                       run_valid;
  logic [LW-1:0]              lvl;
  logic                       lvl_found;
  logic [TASK_SLOTS-1:0]      match;

  logic [2:0]    res_status;
  logic [FW-1:0] res_index;
  logic          res_prev_valid;
  logic [FW-1:0] res_prev_task;

  logic [2:0]    out_status;
  logic [FW-1:0] out_index;
  logic          out_prev_valid;
  logic [FW-1:0] out_prev_task;

  logic                  full;
  logic                  bad_id;
  logic [LW-1:0]         pr_sat;
  logic [IW-1:0]         cnt_idx;
  logic [IW-1:0]         mark_idx;
  logic                  mark_en;
  logic [LW-1:0]         lvl_enc;
  logic [IW-1:0]         pick;
  logic [TASK_SLOTS-1:0] rest;
  logic                  same;

  assign full     = (count == CW'(TASK_SLOTS));
  assign bad_id   = ({2'b00, id} >= 7'(count));
  assign pr_sat   = ({2'b00, pr} >= 7'(PRIORITY_LEVELS)) ? LW'(PRIORITY_LEVELS - 1) : LW'(pr);
  assign cnt_idx  = IW'(count);
  assign mark_idx = (op == pbts_pkg::OP_RELEASE) ? IW'(id) : run_task;
  assign mark_en  = (op == pbts_pkg::OP_RELEASE) ? !bad_id
                  : (op == pbts_pkg::OP_YIELD) && run_valid;

  always_comb begin
    lvl_enc = '0;
    for (int i = PRIORITY_LEVELS - 1; i >= 0; i--) begin
      if (levels[i]) begin
        lvl_enc = LW'(i);
      end
    end
  end

  always_comb begin
    pick = '0;
    for (int i = TASK_SLOTS - 1; i >= 0; i--) begin
      if (match[i]) begin
        pick = IW'(i);
      end
    end
  end

  assign rest = match & ~(TASK_SLOTS'(1) << pick);
  assign same = run_valid && (pick == run_task);

  always_ff @(posedge clk) begin
    if (cmd.exec && op == pbts_pkg::OP_CREATE && !full) begin
      prio[cnt_idx] <= pr_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op <= s_tuser;
      id <= s_tdata[FW-1:0];
      pr <= s_tdata[2*FW-1:FW];
    end
    if (cmd.level) begin
      lvl       <= lvl_enc;
      lvl_found <= |levels;
    end
    if (cmd.match) begin
      for (int i = 0; i < TASK_SLOTS; i++) begin
        match[i] <= ready[i] && (prio[i] == lvl) && (CW'(i) < count) && lvl_found;
      end
    end
    if (cmd.exec) begin
      res_prev_valid <= 1'b0;
      res_prev_task  <= '0;
      unique case (op)
        pbts_pkg::OP_CREATE: begin
          res_status <= full ? pbts_pkg::ST_FULL : pbts_pkg::ST_CREATED;
          res_index  <= full ? '0 : FW'(count);
        end
        pbts_pkg::OP_RELEASE: begin
          res_status <= bad_id ? pbts_pkg::ST_BAD_ID : pbts_pkg::ST_RELEASED;
          res_index  <= bad_id ? '0 : id;
        end
        default: begin
          res_status <= pbts_pkg::ST_NONE;
          res_index  <= '0;
        end
      endcase
    end
    if (cmd.pick && |match) begin
      res_index <= FW'(pick);
      if (same) begin
        res_status <= pbts_pkg::ST_SAME;
      end else begin
        res_status     <= pbts_pkg::ST_SWITCHED;
        res_prev_valid <= run_valid;
        res_prev_task  <= run_valid ? FW'(run_task) : '0;
      end
    end
    if (cmd.push) begin
      out_status     <= res_status;
      out_index      <= res_index;
      out_prev_valid <= res_prev_valid;
      out_prev_task  <= res_prev_task;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ready     <= '0;
      levels    <= '0;
      count     <= '0;
      run_task  <= '0;
      run_valid <= 1'b0;
      m_tvalid  <= 1'b0;
    end else begin
      if (cmd.exec) begin
        if (op == pbts_pkg::OP_CREATE && !full) begin
          ready[cnt_idx] <= 1'b0;
          count          <= count + CW'(1);
        end
        if (mark_en) begin
          ready[mark_idx] <= 1'b1;
          levels          <= levels | (PRIORITY_LEVELS'(1) << prio[mark_idx]);
        end
      end
      if (cmd.pick && |match && !same) begin
        ready[pick] <= 1'b0;
        if (rest == '0) begin
          levels[lvl] <= 1'b0;
        end
        run_task  <= pick;
        run_valid <= 1'b1;
      end
      if (cmd.push) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  assign stat.op       = op;
  assign stat.out_free = !m_tvalid || m_tready;

  assign m_tdata = {6'b0, out_prev_task, out_index};
  assign m_tuser = {out_prev_valid, out_status};

endmodule

// ----- hw/rtl/priority_bitmap_task_scheduler_core.sv -----
// ----------------------------------------------------------------------------
// priority_bitmap_task_scheduler_core
// Fixed-priority task dispatcher with a per-level ready bitmap.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel s_*: one transaction is one operation. s_tuser carries the
//   opcode (create, release, schedule, yield); s_tdata carries task_id and
//   task_priority. Output channel m_*: one transaction per operation, with
//   status and prev_valid in m_tuser and task_index and prev_task in m_tdata.
//   Operations are handled one at a time. Create and release go through
//   execute to the output register; schedule and yield go through execute,
//   level search, task match and pick first. s_tready returns in the cycle
//   right after the result is loaded, so an operation is accepted only once
//   the result of the one before it has been loaded.
//   The output register holds a result until taken; the next operation is
//   accepted meanwhile and its result waits in the datapath while m_tready
//   is low. Reset holds s_tready low and clears the ready marks, the bitmap,
//   the task count and the running task; priorities of tasks never created
//   are not defined.
// ----------------------------------------------------------------------------
module priority_bitmap_task_scheduler_core #(
  parameter int unsigned TASK_SLOTS      = 32,
  parameter int unsigned PRIORITY_LEVELS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // task_id[4:0], task_priority[9:5]
  input  logic [1:0]  s_tuser,   // op[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // task_index[4:0], prev_task[9:5]
  output logic [3:0]  m_tuser    // status[2:0], prev_valid[3]
);

  pbts_pkg::cmd_t  cmd;
  pbts_pkg::stat_t stat;

  pbts_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  pbts_dp #(
    .TASK_SLOTS      (TASK_SLOTS),
    .PRIORITY_LEVELS (PRIORITY_LEVELS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cmd      (cmd),
    .stat     (stat)
  );

endmodule

// ----- hw/rtl/pbts_checker.sv -----
// ----------------------------------------------------------------------------
// pbts_checker
// Port-level checks for the task scheduler core.
// ----------------------------------------------------------------------------
module pbts_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [15:0] s_tdata,
  input logic [1:0]  s_tuser,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata,
  input logic [3:0]  m_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("output transaction changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input accepted while an operation is in progress");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tuser[2:0] != pbts_pkg::ST_UNUSED)
    else $error("undefined status code");

  a_prev_only_switch: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[2:0] != pbts_pkg::ST_SWITCHED |-> !m_tuser[3] && m_tdata[9:5] == 5'd0)
    else $error("previous task reported without a switch");

  a_none_empty: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser[2:0] == pbts_pkg::ST_NONE || m_tuser[2:0] == pbts_pkg::ST_FULL
                 || m_tuser[2:0] == pbts_pkg::ST_BAD_ID) |-> m_tdata[4:0] == 5'd0)
    else $error("task index reported with an empty status");

endmodule

bind priority_bitmap_task_scheduler_core pbts_checker u_pbts_checker (.*);
